@@ rtl/gvc_pkg.sv @@
// Shared types, constants and helpers of the grid vertex corner finder.
package gvc_pkg;

  localparam int unsigned MaxCols = 256;
  localparam int unsigned MaxRows = 256;

  // Counters must hold MaxCols / MaxRows themselves (the far edge vertex).
  localparam int unsigned ColW  = $clog2(MaxCols + 1);
  localparam int unsigned RowW  = $clog2(MaxRows + 1);
  localparam int unsigned LbDepth = MaxCols + 1;
  localparam int unsigned LbAddrW = $clog2(LbDepth);

  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ColW-1:0] MaxColsV = ColW'(MaxCols);
  localparam logic [RowW-1:0] MaxRowsV = RowW'(MaxRows);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegNumCols = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumRows = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginX = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOriginY = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStepX   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStepY   = 3'd5;

  localparam logic signed [DataW-1:0] StepReset = 32'sd65536;

  // One bit per pattern value that is not a corner: 0, 3, 5, 10, 12, 15.
  localparam logic [15:0] NonCornerMask = 16'h9429;

  typedef struct packed {
    logic [ColW-1:0]         num_cols;
    logic [RowW-1:0]         num_rows;
    logic signed [DataW-1:0] origin_x;
    logic signed [DataW-1:0] origin_y;
    logic signed [DataW-1:0] step_x;
    logic signed [DataW-1:0] step_y;
  } cfg_t;

  typedef struct packed {
    logic [ColW-1:0]         vertex_col;
    logic [RowW-1:0]         vertex_row;
    logic [3:0]              pattern;
    logic                    corner;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic                    last;
  } res_t;

  function automatic logic [ColW-1:0] clamp_cols(input logic [ColW-1:0] v);
    logic [ColW-1:0] r;
    if (v == '0) begin
      r = ColW'(1);
    end else if (v > MaxColsV) begin
      r = MaxColsV;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [RowW-1:0] clamp_rows(input logic [RowW-1:0] v);
    logic [RowW-1:0] r;
    if (v == '0) begin
      r = RowW'(1);
    end else if (v > MaxRowsV) begin
      r = MaxRowsV;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic is_corner(input logic [3:0] pat);
    return ~NonCornerMask[pat];
  endfunction

endpackage

@@ rtl/gvc_line_buf.sv @@
// One-row line buffer: single-bit synchronous memory, registered read.
module gvc_line_buf (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [gvc_pkg::LbAddrW-1:0] waddr_i,
  input  logic                        wdata_i,
  input  logic [gvc_pkg::LbAddrW-1:0] raddr_i,
  output logic                        rdata_o
);

  logic mem [gvc_pkg::LbDepth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents; the scan never reads and writes one entry at one edge.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gvc_scan.sv @@
// Vertex scan: counters, neighbour pattern, positions and line buffer access.
module gvc_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        cell_bit_i,
  input  gvc_pkg::cfg_t               cfg_i,
  input  logic                        lb_rdata_i,
  output logic                        lb_we_o,
  output logic [gvc_pkg::LbAddrW-1:0] lb_waddr_o,
  output logic                        lb_wdata_o,
  output logic [gvc_pkg::LbAddrW-1:0] lb_raddr_o,
  output gvc_pkg::res_t               res_o
);

  logic [gvc_pkg::ColW-1:0] col_q, col_d;
  logic [gvc_pkg::RowW-1:0] row_q, row_d;
  logic left_q, left_d;
  logic upl_q, upl_d;
  logic signed [gvc_pkg::DataW-1:0] acc_x_q, acc_x_d;
  logic signed [gvc_pkg::DataW-1:0] acc_y_q, acc_y_d;

  logic [gvc_pkg::ColW-1:0] cols;
  logic [gvc_pkg::RowW-1:0] rows;
  logic row_end, frame_end;
  logic ul, ur, ll, lr;
  logic [3:0] pat;
  logic signed [gvc_pkg::DataW-1:0] px, py;

  always_comb begin
    cols      = gvc_pkg::clamp_cols(cfg_i.num_cols);
    rows      = gvc_pkg::clamp_rows(cfg_i.num_rows);
    row_end   = (col_q >= cols);
    frame_end = row_end && (row_q >= rows);

    // Cells beyond the last column or row are empty.
    lr = (!row_end && (row_q < rows)) ? cell_bit_i : 1'b0;
    ur = ((row_q != '0) && !row_end) ? lb_rdata_i : 1'b0;
    ul = (col_q == '0) ? 1'b0 : upl_q;
    ll = (col_q == '0) ? 1'b0 : left_q;
    pat = {lr, ll, ur, ul};

    px = (col_q == '0) ? cfg_i.origin_x : acc_x_q;
    py = (row_q == '0) ? cfg_i.origin_y : acc_y_q;

    col_d   = col_q;
    row_d   = row_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    left_d  = left_q;
    upl_d   = upl_q;
    if (accept_i) begin
      left_d = lr;
      upl_d  = ur;
      priority if (frame_end) begin
        col_d   = '0;
        row_d   = '0;
        acc_x_d = cfg_i.origin_x;
        acc_y_d = cfg_i.origin_y;
      end else if (row_end) begin
        col_d   = '0;
        row_d   = row_q + gvc_pkg::RowW'(1);
        acc_x_d = cfg_i.origin_x;
        acc_y_d = py + cfg_i.step_y;
      end else begin
        col_d   = col_q + gvc_pkg::ColW'(1);
        acc_x_d = px + cfg_i.step_x;
        acc_y_d = py;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      left_q  <= 1'b0;
      upl_q   <= 1'b0;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      left_q  <= left_d;
      upl_q   <= upl_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  // Prefetch the entry of the next vertex so it is ready when that request arrives.
  assign lb_raddr_o = gvc_pkg::LbAddrW'(col_d);
  assign lb_we_o    = accept_i;
  assign lb_waddr_o = gvc_pkg::LbAddrW'(col_q);
  assign lb_wdata_o = lr;

  always_comb begin
    res_o.vertex_col = col_q;
    res_o.vertex_row = row_q;
    res_o.pattern    = pat;
    res_o.corner     = gvc_pkg::is_corner(pat);
    res_o.pos_x      = px;
    res_o.pos_y      = py;
    res_o.last       = frame_end;
  end

endmodule

@@ rtl/grid_vertex_corner_finder.sv @@
// Top level of the grid vertex corner finder: configuration, scan and output register.
//
// Streams one occupancy bit per vertex of a (num_cols+1) x (num_rows+1) vertex grid in
// row-major order and returns one result per request: vertex indices, the 4-bit
// neighbour pattern (ul bit 0, ur bit 1, ll bit 2, lr bit 3), a corner flag, the
// Q16.16 position and a last-vertex mark. Throughput is one request per clock while no
// result is stalled; a result appears in the cycle after its request is accepted and
// waits in the output register while stalled, and a new request is taken whenever
// that register is empty or being emptied. The line buffer is read one vertex ahead and
// written once per accepted request. After the last vertex the scan restarts at (0,0).
// Write configuration only while no results are outstanding.
module grid_vertex_corner_finder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gvc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gvc_pkg::DataW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cell_bit_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [gvc_pkg::ColW-1:0]           vertex_col_o,
  output logic [gvc_pkg::RowW-1:0]           vertex_row_o,
  output logic [3:0]                         neighbor_pattern_o,
  output logic                               is_corner_o,
  output logic signed [gvc_pkg::DataW-1:0]   pos_x_o,
  output logic signed [gvc_pkg::DataW-1:0]   pos_y_o,
  output logic                               last_vertex_o
);

  gvc_pkg::cfg_t cfg_q;
  gvc_pkg::res_t res, res_q;
  logic out_valid_q;
  logic accept;
  logic lb_we, lb_wdata, lb_rdata;
  logic [gvc_pkg::LbAddrW-1:0] lb_waddr, lb_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_cols <= gvc_pkg::ColW'(1);
      cfg_q.num_rows <= gvc_pkg::RowW'(1);
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.step_x   <= gvc_pkg::StepReset;
      cfg_q.step_y   <= gvc_pkg::StepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gvc_pkg::RegNumCols: cfg_q.num_cols <= cfg_wdata_i[gvc_pkg::ColW-1:0];
        gvc_pkg::RegNumRows: cfg_q.num_rows <= cfg_wdata_i[gvc_pkg::RowW-1:0];
        gvc_pkg::RegOriginX: cfg_q.origin_x <= cfg_wdata_i;
        gvc_pkg::RegOriginY: cfg_q.origin_y <= cfg_wdata_i;
        gvc_pkg::RegStepX:   cfg_q.step_x   <= cfg_wdata_i;
        gvc_pkg::RegStepY:   cfg_q.step_y   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold requests only while a finished result is stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  gvc_line_buf u_line_buf (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  gvc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cell_bit_i (cell_bit_i),
    .cfg_i      (cfg_q),
    .lb_rdata_i (lb_rdata),
    .lb_we_o    (lb_we),
    .lb_waddr_o (lb_waddr),
    .lb_wdata_o (lb_wdata),
    .lb_raddr_o (lb_raddr),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign vertex_col_o       = res_q.vertex_col;
  assign vertex_row_o       = res_q.vertex_row;
  assign neighbor_pattern_o = res_q.pattern;
  assign is_corner_o        = res_q.corner;
  assign pos_x_o            = res_q.pos_x;
  assign pos_y_o            = res_q.pos_y;
  assign last_vertex_o      = res_q.last;

endmodule

@@ rtl/gvc_checker.sv @@
// Port-level checker of the grid vertex corner finder, bound to the top level.
module gvc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [gvc_pkg::ColW-1:0]  vertex_col_o,
  input logic [gvc_pkg::RowW-1:0]  vertex_row_o,
  input logic [3:0]                neighbor_pattern_o,
  input logic                      is_corner_o
);

  // A stalled result stays on offer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted request shows a result in the next cycle.
  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // Requests are held back only by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a stalled result");

  a_corner_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_corner_o == !(neighbor_pattern_o == 4'd0 ||
      neighbor_pattern_o == 4'd3 || neighbor_pattern_o == 4'd5 ||
      neighbor_pattern_o == 4'd10 || neighbor_pattern_o == 4'd12 ||
      neighbor_pattern_o == 4'd15))
    else $error("corner flag disagrees with pattern");

  // The first vertex has no upper or left cells.
  a_origin_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vertex_col_o == '0 && vertex_row_o == '0
      |-> neighbor_pattern_o[2:0] == 3'b000)
    else $error("vertex (0,0) shows upper or left cells");

endmodule

bind grid_vertex_corner_finder gvc_checker u_gvc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .vertex_col_o       (vertex_col_o),
  .vertex_row_o       (vertex_row_o),
  .neighbor_pattern_o (neighbor_pattern_o),
  .is_corner_o        (is_corner_o)
);
